// ===== hw/rtl/quantized_dense_layer_requant_top_assert.svh =====
// Assertion macros shared by the dense layer RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef QUANTIZED_DENSE_LAYER_REQUANT_TOP_ASSERT_SVH
`define QUANTIZED_DENSE_LAYER_REQUANT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define QDLR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define QDLR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QDLR_ASSERT_IMP(label, ante, cons, msg)
`define QDLR_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/qdlr_pkg.sv =====
// Shared types and constants for the quantized dense layer.
// No dependencies.
package qdlr_pkg;

  localparam int ACT_W      = 8;
  localparam int WGT_W      = 8;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = ACT_W + 1 + WGT_W;
  localparam int ACC_W      = 40;
  localparam int SHIFT_W    = 6;
  localparam int INDEX_W    = 6;
  localparam int MAX_NEURONS = 64;
  localparam int MULT_W     = 2 * DATA_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_IN_ZP    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUT_ZP   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MULT     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RELU     = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]         in_zp;
    logic [ACT_W-1:0]         out_zp;
    logic signed [DATA_W-1:0] mult;
    logic [SHIFT_W-1:0]       shift;
    logic                     relu;
  } cfg_t;

  // one finished row, handed from the MAC to the requant engine
  typedef struct packed {
    logic signed [ACC_W-1:0]  acc;
    logic signed [DATA_W-1:0] bias;
    logic                     last;
  } entry_t;

endpackage

// ===== hw/rtl/qdlr_front.sv =====
// MAC front end: takes one beat per cycle while the queue is not full, accumulates with 40-bit saturation.
// Depends on qdlr_pkg.
module qdlr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [qdlr_pkg::ACT_W-1:0]       activation,
  input  logic signed [qdlr_pkg::WGT_W-1:0] weight,
  input  logic signed [qdlr_pkg::DATA_W-1:0] bias,
  input  logic                             row_last,
  input  logic                             layer_last,
  input  logic [qdlr_pkg::ACT_W-1:0]       in_zp,
  input  logic                             queue_full,
  output logic                             push,
  output qdlr_pkg::entry_t                 push_entry
);

  logic signed [qdlr_pkg::ACC_W-1:0]  acc;
  logic signed [qdlr_pkg::ACC_W-1:0]  acc_next;
  logic signed [qdlr_pkg::ACT_W:0]    act_off;
  logic signed [qdlr_pkg::PROD_W-1:0] prod;
  logic signed [qdlr_pkg::ACC_W:0]    sum_ext;
  logic                               accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  // (activation - zero point) * weight
  assign act_off = $signed({1'b0, activation}) - $signed({1'b0, in_zp});
  assign prod    = act_off * weight;

  // saturating add into the accumulator
  assign sum_ext = $signed({acc[qdlr_pkg::ACC_W-1], acc})
                 + $signed({{(qdlr_pkg::ACC_W + 1 - qdlr_pkg::PROD_W){prod[qdlr_pkg::PROD_W-1]}},
                            prod});

  always_comb begin
    if (sum_ext[qdlr_pkg::ACC_W] == sum_ext[qdlr_pkg::ACC_W-1]) begin
      acc_next = sum_ext[qdlr_pkg::ACC_W-1:0];
    end else if (sum_ext[qdlr_pkg::ACC_W]) begin
      acc_next = {1'b1, {(qdlr_pkg::ACC_W-1){1'b0}}};
    end else begin
      acc_next = {1'b0, {(qdlr_pkg::ACC_W-1){1'b1}}};
    end
  end

  assign push            = accept && row_last;
  assign push_entry.acc  = acc_next;
  assign push_entry.bias = bias;
  assign push_entry.last = layer_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (accept) begin
      acc <= row_last ? '0 : acc_next;
    end
  end

endmodule

// ===== hw/rtl/qdlr_queue.sv =====
// Short queue of finished rows between the MAC and the requant engine.
// Depends on qdlr_pkg and the assertion macro header.
`include "quantized_dense_layer_requant_top_assert.svh"

module qdlr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qdlr_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output qdlr_pkg::entry_t head
);

  qdlr_pkg::entry_t slots [qdlr_pkg::QUEUE_DEPTH];
  logic [qdlr_pkg::QPTR_W-1:0] wr_ptr;
  logic [qdlr_pkg::QPTR_W-1:0] rd_ptr;
  logic [qdlr_pkg::QCNT_W-1:0] count;

  assign full       = (count == qdlr_pkg::QCNT_W'(qdlr_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `QDLR_ASSERT_IMP(a_no_push_full, push, !full, "row pushed into a full queue")
  `QDLR_ASSERT_IMP(a_no_pop_empty, pop, head_valid, "row popped from an empty queue")
  `QDLR_ASSERT_IMP(a_count_range, 1'b1, count <= qdlr_pkg::QCNT_W'(qdlr_pkg::QUEUE_DEPTH), "queue fill level out of range")

endmodule

// ===== hw/rtl/qdlr_back.sv =====
// Requant engine: bias, int32 clamp, scale, rounding shift, output clamp, argmax.
// Depends on qdlr_pkg and the assertion macro header.
`include "quantized_dense_layer_requant_top_assert.svh"

module qdlr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  qdlr_pkg::cfg_t                cfg,
  input  logic                          entry_valid,
  input  qdlr_pkg::entry_t              entry,
  output logic                          entry_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [qdlr_pkg::ACT_W-1:0]    neuron_value,
  output logic [qdlr_pkg::INDEX_W-1:0]  neuron_index,
  output logic [qdlr_pkg::INDEX_W-1:0]  best_index,
  output logic                          layer_done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t state;

  logic signed [qdlr_pkg::DATA_W-1:0] total;
  logic signed [qdlr_pkg::MULT_W-1:0] prod;
  logic signed [qdlr_pkg::MULT_W-1:0] quot;
  logic                               last;

  logic [qdlr_pkg::INDEX_W-1:0] cnt;
  logic [qdlr_pkg::ACT_W-1:0]   best_value;
  logic [qdlr_pkg::INDEX_W-1:0] best_position;
  logic                         best_valid;

  logic signed [qdlr_pkg::ACC_W:0]    bias_sum;
  logic signed [qdlr_pkg::DATA_W-1:0] total_next;
  logic signed [qdlr_pkg::MULT_W-1:0] prod_next;
  logic signed [qdlr_pkg::MULT_W-1:0] shifted;
  logic                               round_bit;
  logic signed [qdlr_pkg::MULT_W-1:0] quot_next;
  logic signed [qdlr_pkg::MULT_W:0]   biased;
  logic [qdlr_pkg::ACT_W-1:0]         low_bound;
  logic [qdlr_pkg::ACT_W-1:0]         value_next;
  logic                               take_best;
  logic [qdlr_pkg::INDEX_W-1:0]       best_pos_next;
  logic                               out_load;

  // bias add and int32 clamp, straight off the queue head
  assign bias_sum = $signed({entry.acc[qdlr_pkg::ACC_W-1], entry.acc})
                  + $signed({{(qdlr_pkg::ACC_W + 1 - qdlr_pkg::DATA_W){entry.bias[qdlr_pkg::DATA_W-1]}},
                             entry.bias});

  always_comb begin
    if (&bias_sum[qdlr_pkg::ACC_W:qdlr_pkg::DATA_W-1] ||
        ~|bias_sum[qdlr_pkg::ACC_W:qdlr_pkg::DATA_W-1]) begin
      total_next = bias_sum[qdlr_pkg::DATA_W-1:0];
    end else if (bias_sum[qdlr_pkg::ACC_W]) begin
      total_next = {1'b1, {(qdlr_pkg::DATA_W-1){1'b0}}};
    end else begin
      total_next = {1'b0, {(qdlr_pkg::DATA_W-1){1'b1}}};
    end
  end

  // 32x32 scale
  assign prod_next = total * cfg.mult;

  // arithmetic shift with round half up; shift 0 passes through
  assign shifted   = prod >>> cfg.shift;
  assign round_bit = prod[cfg.shift - 1'b1];
  assign quot_next = (cfg.shift == '0) ? prod
                   : shifted + $signed({{(qdlr_pkg::MULT_W-1){1'b0}}, round_bit});

  // Add the output zero point on the full-width quotient; an int32 clamp
  // first would land on the same byte, since both rails sit outside [0,255].
  assign biased    = $signed({quot[qdlr_pkg::MULT_W-1], quot})
                   + $signed({{(qdlr_pkg::MULT_W + 1 - qdlr_pkg::ACT_W){1'b0}}, cfg.out_zp});
  assign low_bound = cfg.relu ? cfg.out_zp : '0;

  always_comb begin
    if (!biased[qdlr_pkg::MULT_W] && |biased[qdlr_pkg::MULT_W-1:qdlr_pkg::ACT_W]) begin
      value_next = '1;
    end else if (biased[qdlr_pkg::MULT_W] || biased[qdlr_pkg::ACT_W-1:0] < low_bound) begin
      value_next = low_bound;
    end else begin
      value_next = biased[qdlr_pkg::ACT_W-1:0];
    end
  end

  // first maximum wins
  assign take_best     = !best_valid || (value_next > best_value);
  assign best_pos_next = take_best ? cnt : best_position;

  assign entry_pop = (state == S_IDLE) && entry_valid;
  assign out_load  = (state == S_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      cnt           <= '0;
      best_value    <= '0;
      best_position <= '0;
      best_valid    <= 1'b0;
    end else begin
      // output beat leaves when taken and nothing replaces it
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (entry_valid) begin
            total <= total_next;
            last  <= entry.last;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= prod_next;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          quot  <= quot_next;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            out_valid     <= 1'b1;
            neuron_value  <= value_next;
            neuron_index  <= cnt;
            best_index    <= best_pos_next;
            layer_done    <= last;
            if (take_best) begin
              best_value    <= value_next;
              best_position <= cnt;
            end
            if (last) begin
              best_valid <= 1'b0;
              cnt        <= '0;
            end else begin
              best_valid <= 1'b1;
              cnt        <= (cnt == qdlr_pkg::INDEX_W'(qdlr_pkg::MAX_NEURONS - 1))
                            ? '0 : cnt + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `QDLR_ASSERT_NXT(a_beat_holds, out_valid && out_stall, out_valid && $stable(neuron_value), "stalled result beat changed")
  `QDLR_ASSERT_NXT(a_layer_resets, out_load && last, cnt == '0 && !best_valid, "layer end did not clear neuron count")
  `QDLR_ASSERT_NXT(a_row_sets_best, out_load && !last, best_valid, "argmax not valid after a row")
  `QDLR_ASSERT_NXT(a_finish_holds, state == S_FINISH && out_valid && out_stall, state == S_FINISH, "result dropped under stall")

endmodule

// ===== hw/rtl/quantized_dense_layer_requant_top.sv =====
// Top level of the int8 dense layer with requantization and argmax.
// Depends on qdlr_pkg, qdlr_front, qdlr_queue and qdlr_back.
//
// Each input beat carries one activation/weight pair; the MAC front end takes
// one beat per clock whenever its two-entry row queue has room, so rows stream
// at one element per cycle. A beat with row_last set closes the neuron: the
// requant engine then works through it step by step (bias and int32 clamp,
// 32x32 multiply, rounding shift, output clamp with argmax update), one row at
// a time. Rows at least as long as that step list sustain one beat per cycle
// while out_stall is low; shorter rows wait on the engine once the queue fills.
// One result beat comes out per row, carrying the byte, its neuron index, the
// running first-maximum index and a layer-end flag. Configuration is written
// through a plain write port and should change only while the block is idle.
module quantized_dense_layer_requant_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [qdlr_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [qdlr_pkg::DATA_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [qdlr_pkg::ACT_W-1:0]         activation,
  input  logic signed [qdlr_pkg::WGT_W-1:0]  weight,
  input  logic signed [qdlr_pkg::DATA_W-1:0] bias,
  input  logic                               row_last,
  input  logic                               layer_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [qdlr_pkg::ACT_W-1:0]         neuron_value,
  output logic [qdlr_pkg::INDEX_W-1:0]       neuron_index,
  output logic [qdlr_pkg::INDEX_W-1:0]       best_index,
  output logic                               layer_done
);

  qdlr_pkg::cfg_t   cfg;
  qdlr_pkg::entry_t push_entry;
  qdlr_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             queue_full;
  logic             head_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_zp  <= '0;
      cfg.out_zp <= '0;
      cfg.mult   <= qdlr_pkg::DATA_W'(1);
      cfg.shift  <= '0;
      cfg.relu   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        qdlr_pkg::REG_IN_ZP:  cfg.in_zp  <= cfg_data[qdlr_pkg::ACT_W-1:0];
        qdlr_pkg::REG_OUT_ZP: cfg.out_zp <= cfg_data[qdlr_pkg::ACT_W-1:0];
        qdlr_pkg::REG_MULT:   cfg.mult   <= cfg_data;
        qdlr_pkg::REG_SHIFT:  cfg.shift  <= cfg_data[qdlr_pkg::SHIFT_W-1:0];
        qdlr_pkg::REG_RELU:   cfg.relu   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  qdlr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .activation (activation),
    .weight     (weight),
    .bias       (bias),
    .row_last   (row_last),
    .layer_last (layer_last),
    .in_zp      (cfg.in_zp),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  qdlr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  qdlr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .entry_valid  (head_valid),
    .entry        (head),
    .entry_pop    (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .neuron_value (neuron_value),
    .neuron_index (neuron_index),
    .best_index   (best_index),
    .layer_done   (layer_done)
  );

endmodule

// ===== verif/qdlr_layer_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the quantized dense layer: tracks the config port, predicts
// every neuron beat from the accepted input beats and compares it on arrival.
// Depends on qdlr_pkg.
module qdlr_layer_checker
  import qdlr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [REG_IDX_W-1:0]      cfg_index,
  input  logic [DATA_W-1:0]         cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [ACT_W-1:0]          activation,
  input  logic signed [WGT_W-1:0]   weight,
  input  logic signed [DATA_W-1:0]  bias,
  input  logic                      row_last,
  input  logic                      layer_last,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [ACT_W-1:0]          neuron_value,
  input  logic [INDEX_W-1:0]        neuron_index,
  input  logic [INDEX_W-1:0]        best_index,
  input  logic                      layer_done,
  output int                        errors,
  output int                        outstanding
);

  localparam longint ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam longint ACC_MIN = -ACC_MAX - 64'sd1;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -I32_MAX - 64'sd1;

  typedef struct packed {
    logic [ACT_W-1:0]   value;
    logic [INDEX_W-1:0] index;
    logic [INDEX_W-1:0] best;
    logic               done;
  } neuron_t;

  // shadow of the config registers and of the datapath state
  cfg_t               cfg;
  longint             dot_sum;
  logic [INDEX_W-1:0] neuron_count;
  logic [ACT_W-1:0]   peak_value;
  logic [INDEX_W-1:0] peak_pos;
  logic               peak_seen;
  neuron_t            expected_neurons[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // scale the int32 total, round half up, then clamp into the output byte
  function automatic logic [ACT_W-1:0] requant_byte(longint total);
    longint prod;
    longint q;
    prod = total * longint'($signed(cfg.mult));
    if (cfg.shift == 0) begin
      q = prod;
    end else begin
      q = (prod >>> cfg.shift) + (prod[cfg.shift - 1'b1] ? 64'sd1 : 64'sd0);
    end
    q = clip(q, I32_MIN, I32_MAX) + longint'(cfg.out_zp);
    q = clip(q, cfg.relu ? longint'(cfg.out_zp) : 64'sd0, 64'sd255);
    return q[ACT_W-1:0];
  endfunction

  // fold one accepted input beat into the running row; queue a result on row end
  task automatic absorb_element();
    longint  prod;
    longint  acc;
    longint  total;
    neuron_t r;
    prod = (longint'(activation) - longint'(cfg.in_zp)) * longint'(weight);
    acc = clip(dot_sum + prod, ACC_MIN, ACC_MAX);
    if (!row_last) begin
      dot_sum = acc;
      return;
    end
    total = clip(acc + longint'(bias), I32_MIN, I32_MAX);
    r.value = requant_byte(total);
    r.index = neuron_count;
    // strict compare keeps the earliest maximum
    if (!peak_seen || r.value > peak_value) begin
      peak_value = r.value;
      peak_pos = neuron_count;
      peak_seen = 1'b1;
    end
    r.best = peak_pos;
    r.done = layer_last;
    expected_neurons.push_back(r);
    dot_sum = 0;
    if (layer_last) begin
      neuron_count = '0;
      peak_seen = 1'b0;
    end else begin
      neuron_count = (neuron_count == INDEX_W'(MAX_NEURONS - 1)) ? '0 : neuron_count + 1'b1;
    end
  endtask

  task automatic flag(string field, int unsigned want, int unsigned got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    neuron_t want;
    if (rst) begin
      cfg.in_zp = '0;
      cfg.out_zp = '0;
      cfg.mult = 1;
      cfg.shift = '0;
      cfg.relu = 1'b0;
      dot_sum = 0;
      neuron_count = '0;
      peak_value = '0;
      peak_pos = '0;
      peak_seen = 1'b0;
      expected_neurons.delete();
    end else begin
      // the user must write registers only while idle (the block does not enforce it); order vs. beats is then moot
      if (cfg_write) begin
        case (cfg_index)
          REG_IN_ZP:  cfg.in_zp = cfg_data[ACT_W-1:0];
          REG_OUT_ZP: cfg.out_zp = cfg_data[ACT_W-1:0];
          REG_MULT:   cfg.mult = cfg_data;
          REG_SHIFT:  cfg.shift = cfg_data[SHIFT_W-1:0];
          REG_RELU:   cfg.relu = cfg_data[0];
          default: ;
        endcase
      end
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_neurons.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, expected none, actual value %0d index %0d",
                   $time, neuron_value, neuron_index);
        end else begin
          want = expected_neurons.pop_front();
          if (neuron_value !== want.value)
            flag("neuron_value", 32'(want.value), 32'(neuron_value));
          if (neuron_index !== want.index)
            flag("neuron_index", 32'(want.index), 32'(neuron_index));
          if (best_index !== want.best)
            flag("best_index", 32'(want.best), 32'(best_index));
          if (layer_done !== want.done)
            flag("layer_done", 32'(want.done), 32'(layer_done));
        end
      end
      if (in_valid && !in_stall) absorb_element();
    end
    outstanding <= expected_neurons.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the quantized dense layer: clock, reset, register setup and
// input beats with random idling on both sides; qdlr_layer_checker does the checks.
// Depends on qdlr_pkg, quantized_dense_layer_requant_top and qdlr_layer_checker.
module tb;
  import qdlr_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BEATS  = 80;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]      cfg_index = '0;
  logic [DATA_W-1:0]         cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [ACT_W-1:0]          activation = '0;
  logic signed [WGT_W-1:0]   weight = '0;
  logic signed [DATA_W-1:0]  bias = '0;
  logic                      row_last = 1'b0;
  logic                      layer_last = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [ACT_W-1:0]          neuron_value;
  logic [INDEX_W-1:0]        neuron_index;
  logic [INDEX_W-1:0]        best_index;
  logic                      layer_done;
  int                        errors;
  int                        outstanding;

  // calm turns idling off on both sides; long_hold asks the receiver for a long stall
  bit calm = 1'b0;
  bit long_hold = 1'b0;

  always #2 clk = ~clk;

  quantized_dense_layer_requant_top uut (.*);

  qdlr_layer_checker layer_check (.*);

  // one input beat, optionally after an idle burst; valid stays up afterwards
  task automatic put_element(input logic [ACT_W-1:0] act, input logic [WGT_W-1:0] wgt,
                             input logic [DATA_W-1:0] b, input logic rl, input logic ll);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    activation <= act;
    weight <= wgt;
    bias <= b;
    row_last <= rl;
    layer_last <= ll;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending, wait for every predicted result, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper data bits carry junk on the narrow registers
  task automatic set_scaling(input logic [ACT_W-1:0] izp, input logic [ACT_W-1:0] ozp,
                             input logic [DATA_W-1:0] mult, input logic [SHIFT_W-1:0] shift,
                             input logic relu);
    settle();
    write_reg(REG_IN_ZP, ($urandom & 32'hFFFF_FF00) | DATA_W'(izp));
    write_reg(REG_OUT_ZP, ($urandom & 32'hFFFF_FF00) | DATA_W'(ozp));
    write_reg(REG_MULT, mult);
    write_reg(REG_SHIFT, ($urandom & ~32'h3F) | DATA_W'(shift));
    write_reg(REG_RELU, ($urandom & ~32'h1) | DATA_W'(relu));
  endtask

  function automatic logic [ACT_W-1:0] pick_zero_point();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 8'hFF;
      default: return ACT_W'($urandom);
    endcase
  endfunction

  // well-formed layers of random rows; mid-row layer_last is noise the block ignores
  task automatic random_rows(input int beats);
    int sent;
    int neurons;
    int len;
    sent = 0;
    while (sent < beats) begin
      neurons = $urandom_range(1, 8);
      for (int r = 0; r < neurons; r++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        for (int e = 0; e < len; e++) begin
          if (e == len - 1) begin
            put_element(ACT_W'($urandom), WGT_W'($urandom),
                        ($urandom_range(0, 3) == 0) ? $urandom
                                                    : DATA_W'($urandom_range(0, 8191) - 4096),
                        1'b1, r == neurons - 1);
          end else begin
            put_element(ACT_W'($urandom), WGT_W'($urandom), $urandom, 1'b0,
                        $urandom_range(0, 3) == 0);
          end
        end
        sent += len;
      end
    end
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0]  mult;
    logic [SHIFT_W-1:0] shift;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset scaling (multiply by one, no shift): field extremes and clamps
    put_element(8'd255, 8'sd127, 32'd0, 1'b1, 1'b0);
    put_element(8'd0, -8'sd128, 32'd0, 1'b1, 1'b0);
    put_element(8'd255, -8'sd128, 32'd100, 1'b1, 1'b0);
    put_element(8'd10, 8'sd3, $urandom, 1'b0, 1'b0);
    put_element(8'd20, -8'sd1, $urandom, 1'b0, 1'b1);
    put_element(8'd5, 8'sd2, 32'd7, 1'b1, 1'b0);
    put_element(8'd255, 8'sd127, 32'h7FFF_FFFF, 1'b1, 1'b0);
    put_element(8'd255, -8'sd128, 32'h8000_0000, 1'b1, 1'b0);
    put_element(8'd13, 8'sd1, 32'd0, 1'b1, 1'b1);

    // argmax ties: the earlier neuron wins
    put_element(8'd50, 8'sd1, 32'd0, 1'b1, 1'b0);
    put_element(8'd50, 8'sd1, 32'd0, 1'b1, 1'b0);
    put_element(8'd30, 8'sd1, 32'd0, 1'b1, 1'b0);
    put_element(8'd80, 8'sd1, 32'd0, 1'b1, 1'b0);
    put_element(8'd80, 8'sd1, 32'd0, 1'b1, 1'b1);

    // a write to an unmapped index changes nothing
    settle();
    write_reg(REG_SPARE, $urandom);
    put_element(8'd7, 8'sd9, 32'd0, 1'b1, 1'b1);

    // register extremes, including the widest shift
    set_scaling(8'hFF, 8'hFF, 32'h8000_0000, 6'd63, 1'b1);
    put_element(8'd0, -8'sd128, 32'h7FFF_FFFF, 1'b1, 1'b0);
    put_element(8'd255, 8'sd127, 32'd0, 1'b1, 1'b1);
    set_scaling(8'h00, 8'h00, 32'h7FFF_FFFF, 6'd62, 1'b0);
    put_element(8'd255, 8'sd127, 32'h7FFF_FFFF, 1'b1, 1'b0);
    put_element(8'd0, 8'sd1, 32'h8000_0000, 1'b1, 1'b1);

    // shift by one: halves round up
    set_scaling(8'h00, 8'h00, 32'd1, 6'd1, 1'b0);
    put_element(8'd3, 8'sd1, 32'd0, 1'b1, 1'b0);
    put_element(8'd255, 8'sd1, -32'sd2, 1'b1, 1'b1);

    // random phases, each under its own scaling
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 7);

      // long row: a large positive sum pulled down by the most negative bias
      if (ph == 6) begin
        set_scaling(8'h00, 8'h00, 32'd1, 6'd20, 1'b0);
        calm = 1'b1;
        repeat (60) put_element(8'd255, 8'sd127, $urandom, 1'b0, 1'b0);
        put_element(8'd255, 8'sd127, 32'h8000_0000, 1'b1, 1'b1);
        calm = 1'b0;
      end

      case ($urandom_range(0, 7))
        0: mult = 32'h8000_0000;
        1: mult = 32'h7FFF_FFFF;
        2: mult = $urandom;
        3: mult = -DATA_W'($urandom_range(32'h2000_0000, 32'h7FFF_FFFF));
        default: mult = $urandom_range(32'h2000_0000, 32'h7FFF_FFFF);
      endcase
      case ($urandom_range(0, 5))
        0: shift = '0;
        1: shift = 6'd63;
        2: shift = SHIFT_W'($urandom_range(0, 63));
        default: shift = SHIFT_W'($urandom_range(30, 44));
      endcase
      set_scaling(pick_zero_point(), pick_zero_point(), mult, shift,
                  $urandom_range(0, 1) == 1);

      // receiver holds off while single-element rows back up into the input
      if (ph == 3) begin
        long_hold = 1'b1;
        calm = 1'b1;
        repeat (40) put_element(ACT_W'($urandom), WGT_W'($urandom), $urandom, 1'b1,
                                $urandom_range(0, 7) == 0);
        calm = 1'b0;
      end

      // one layer longer than the neuron counter: index wraps to zero
      if (ph == 5) begin
        repeat (70) put_element(ACT_W'($urandom), WGT_W'($urandom), $urandom, 1'b1, 1'b0);
        put_element(ACT_W'($urandom), WGT_W'($urandom), $urandom, 1'b1, 1'b1);
      end

      random_rows(PHASE_BEATS);
    end

    settle();
    if (errors == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/qdlr_pkg.sv
hw/rtl/qdlr_front.sv
hw/rtl/qdlr_queue.sv
hw/rtl/qdlr_back.sv
hw/rtl/quantized_dense_layer_requant_top.sv
verif/qdlr_layer_checker.sv
verif/tb.sv
